/* rtl/sau_pkg.sv */
// package: codes, control word format and microcode program of the stack arithmetic unit
package sau_pkg;

	localparam int DATA_W = 32;
	localparam int DEFAULT_STACK_DEPTH = 64;
	localparam int PC_W = 4;
	localparam int DEPTH_OUT_W = 7;

	localparam logic [2:0] MODE_PUSH = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_SUB  = 3'd2;
	localparam logic [2:0] MODE_DIV  = 3'd3;
	localparam logic [2:0] MODE_MUL  = 3'd4;
	localparam logic [2:0] MODE_MOD  = 3'd5;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_RD,
		UOP_LDA,
		UOP_ALU,
		UOP_WRB,
		UOP_DSTART,
		UOP_LDD,
		UOP_PUSH
	} uop_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_PUSH,
		C_NOTBIN,
		C_SHORT,
		C_DIVZERO,
		C_DIVOP,
		C_DIVBUSY,
		C_FULL
	} cond_t;

	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            done;
		status_t         status;
	} uword_t;

	localparam logic [PC_W-1:0] PC_WRB   = 4'd6;
	localparam logic [PC_W-1:0] PC_DIV   = 4'd7;
	localparam logic [PC_W-1:0] PC_DWAIT = 4'd8;
	localparam logic [PC_W-1:0] PC_PUSH  = 4'd10;
	localparam logic [PC_W-1:0] PC_OK    = 4'd12;
	localparam logic [PC_W-1:0] PC_SHORT = 4'd13;
	localparam logic [PC_W-1:0] PC_DZ    = 4'd14;
	localparam logic [PC_W-1:0] PC_FULL  = 4'd15;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: UOP_NOP, cond: C_NEVER, target: '0, done: 1'b0, status: ST_OK};
		case (pc)
			4'd0:  begin w.cond = C_PUSH;    w.target = PC_PUSH;  end
			4'd1:  begin w.cond = C_NOTBIN;  w.target = PC_OK;    end
			4'd2:  begin w.cond = C_SHORT;   w.target = PC_SHORT; end
			4'd3:  begin w.op = UOP_RD;  w.cond = C_DIVZERO; w.target = PC_DZ; end
			4'd4:  begin w.op = UOP_LDA; w.cond = C_DIVOP;   w.target = PC_DIV; end
			4'd5:  begin w.op = UOP_ALU; end
			4'd6:  begin w.op = UOP_WRB; w.cond = C_ALWAYS;  w.target = PC_OK; end
			4'd7:  begin w.op = UOP_DSTART; end
			4'd8:  begin w.cond = C_DIVBUSY; w.target = PC_DWAIT; end
			4'd9:  begin w.op = UOP_LDD; w.cond = C_ALWAYS;  w.target = PC_WRB; end
			4'd10: begin w.cond = C_FULL;    w.target = PC_FULL;  end
			4'd11: begin w.op = UOP_PUSH; w.cond = C_ALWAYS; w.target = PC_OK; end
			4'd12: begin w.done = 1'b1; w.status = ST_OK;      end
			4'd13: begin w.done = 1'b1; w.status = ST_SHORT;   end
			4'd14: begin w.done = 1'b1; w.status = ST_DIVZERO; end
			4'd15: begin w.done = 1'b1; w.status = ST_FULL;    end
			default: begin w.done = 1'b1; end
		endcase
		return w;
	endfunction

endpackage

/* rtl/sau_ram.sv */
// generic single-port-write ram with registered read
module sau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/sau_divider.sv */
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module sau_divider
	import sau_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] dividend,
	input  logic signed [DATA_W-1:0] divisor,
	output logic                     busy,
	output logic signed [DATA_W-1:0] quotient,
	output logic signed [DATA_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DATA_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W:0]  rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dsr_q;
	logic             qneg_q;
	logic             rneg_q;

	logic [DATA_W-1:0] abs_a;
	logic [DATA_W-1:0] abs_b;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	assign abs_a   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_b   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
	assign shifted = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= abs_a;
			dsr_q  <= abs_b;
			qneg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rneg_q <= dividend[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = qneg_q ? (~quo_q + 1'b1) : quo_q;
	assign remainder = rneg_q ? (~rem_q[DATA_W-1:0] + 1'b1) : rem_q[DATA_W-1:0];

endmodule

/* rtl/stack_arithmetic_unit.sv */
// top level: microcoded operand stack with push, add, sub, mul, div and mod
//
//  channel  signals                          dir  notes
//  in       in_valid in_ready mode push_value in   one word per operation
//  out      out_valid out_ready status        out  one word per input word
//           top_value depth
//
//  time from acceptance to result grows in this order: full push and unused modes, push and
//  short stack, a zero divisor, add/sub/mul, and div and mod (divider)
//  one word in flight; the next is taken only after the result is registered, so div and
//  mod hold off the next word longest
//  a pending result blocks the final microcode step until it is taken
//  reset clears count, sequencer and output valid; stack ram is not cleared
module stack_arithmetic_unit
	import sau_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               mode,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] top_value,
	output logic [DEPTH_OUT_W-1:0]   depth
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic                  busy_q;
	logic [PC_W-1:0]       pc_q;
	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [DATA_W-1:0]     top_out_q;
	logic [DEPTH_OUT_W-1:0] depth_q;

	logic [2:0]            mode_q;
	logic [DATA_W-1:0]     val_q;
	logic [DATA_W-1:0]     top_q;
	logic [DATA_W-1:0]     a_q;
	logic [DATA_W-1:0]     b_q;
	logic [DATA_W-1:0]     res_q;

	uword_t                uw;
	logic                  jump;
	logic                  is_divop;
	logic                  done_go;
	logic [CW-1:0]         sec_idx;
	logic [CW+DEPTH_OUT_W-1:0] cnt_wide;
	logic [DATA_W-1:0]     mul_lo;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_W-1:0]     ram_wdata;
	logic [DATA_W-1:0]     ram_rdata;

	logic                  div_start;
	logic                  div_busy;
	logic signed [DATA_W-1:0] div_quo;
	logic signed [DATA_W-1:0] div_rem;

	assign uw       = ucode(pc_q);
	assign is_divop = (mode_q == MODE_DIV) || (mode_q == MODE_MOD);
	assign sec_idx  = count_q - CW'(2);
	assign cnt_wide = {{DEPTH_OUT_W{1'b0}}, count_q};
	assign done_go  = !out_valid_q || out_ready;
	assign mul_lo   = a_q * b_q;

	always_comb begin
		case (uw.cond)
			C_NEVER:   jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_PUSH:    jump = (mode_q == MODE_PUSH);
			C_NOTBIN:  jump = (mode_q > MODE_MOD);
			C_SHORT:   jump = (count_q < CW'(2));
			C_DIVZERO: jump = is_divop && (top_q == '0);
			C_DIVOP:   jump = is_divop;
			C_DIVBUSY: jump = div_busy;
			C_FULL:    jump = (count_q == CW'(STACK_DEPTH));
			default:   jump = 1'b0;
		endcase
	end

	assign ram_we    = busy_q && ((uw.op == UOP_WRB) || (uw.op == UOP_PUSH));
	assign ram_waddr = (uw.op == UOP_PUSH) ? count_q[AW-1:0] : sec_idx[AW-1:0];
	assign ram_wdata = (uw.op == UOP_PUSH) ? val_q : res_q;
	assign div_start = busy_q && (uw.op == UOP_DSTART);

	sau_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (sec_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	sau_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (a_q),
		.divisor   (b_q),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer, stack count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q && uw.done && done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (in_valid) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else if (uw.done) begin
				if (done_go) begin
					busy_q <= 1'b0;
				end
			end else begin
				pc_q <= jump ? uw.target : pc_q + 1'b1;
				if (uw.op == UOP_WRB) begin
					count_q <= count_q - 1'b1;
				end else if (uw.op == UOP_PUSH) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// datapath and output words
	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			mode_q <= mode;
			val_q  <= push_value;
		end
		if (busy_q) begin
			case (uw.op)
				UOP_LDA: begin
					a_q <= ram_rdata;
					b_q <= top_q;
				end
				UOP_ALU: begin
					case (mode_q)
						MODE_ADD: res_q <= a_q + b_q;
						MODE_SUB: res_q <= a_q - b_q;
						default:  res_q <= mul_lo;
					endcase
				end
				UOP_LDD: res_q <= (mode_q == MODE_DIV) ? div_quo : div_rem;
				UOP_WRB:  top_q <= res_q;
				UOP_PUSH: top_q <= val_q;
				default: begin
				end
			endcase
			if (uw.done && done_go) begin
				status_q  <= uw.status;
				top_out_q <= (count_q == '0) ? '0 : top_q;
				depth_q   <= cnt_wide[DEPTH_OUT_W-1:0];
			end
		end
	end

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign top_value = top_out_q;
	assign depth     = depth_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !div_busy)
		else $error("divider busy while sequencer idle");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && uw.op == UOP_PUSH) |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the stack");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && uw.op == UOP_WRB) |-> count_q >= CW'(2))
		else $error("binary write with short stack");
`endif

endmodule
